// ===== rtl/lbs_pkg.sv =====
// Package for the LED blink sequencer: item types, operation codes and
// default widths. Used by every module of the block; depends on nothing.
package lbs_pkg;

   localparam int TimeWidthDefault  = 32;
   localparam int CountWidthDefault = 8;

   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [7:0]  priority_req;
      logic [31:0] delay_before;
      logic [31:0] delay_after;
      logic [31:0] on_time;
      logic [31:0] off_time;
      logic [7:0]  cycles;
   } req_type;

   typedef struct packed {
      logic led_on;
      logic busy_res;
      logic accepted;
   } rsp_type;

endpackage

// ===== rtl/lbs_core.sv =====
// Sequencer state and next-state logic of the LED blink sequencer.
// Depends on lbs_pkg for the item types and operation codes.
module lbs_core #(
   parameter int TIME_WIDTH  = lbs_pkg::TimeWidthDefault,
   parameter int COUNT_WIDTH = lbs_pkg::CountWidthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_take,
   input  lbs_pkg::req_type item,
   output lbs_pkg::rsp_type result
);

   localparam logic [2:0] PH_IDLE        = 3'd0;
   localparam logic [2:0] PH_WAIT_BEFORE = 3'd1;
   localparam logic [2:0] PH_SWITCH_ON   = 3'd2;
   localparam logic [2:0] PH_WAIT_ON     = 3'd3;
   localparam logic [2:0] PH_SWITCH_OFF  = 3'd4;
   localparam logic [2:0] PH_WAIT_OFF    = 3'd5;
   localparam logic [2:0] PH_WAIT_AFTER  = 3'd6;

   logic [2:0]             phase_ff, phase_in;
   logic                   active_ff, active_in;
   logic                   led_ff, led_in;
   logic [7:0]             prio_ff, prio_in;
   logic [TIME_WIDTH-1:0]  before_ff, before_in;
   logic [TIME_WIDTH-1:0]  after_ff, after_in;
   logic [TIME_WIDTH-1:0]  on_ff, on_in;
   logic [TIME_WIDTH-1:0]  off_ff, off_in;
   logic [COUNT_WIDTH-1:0] left_ff, left_in;
   logic [TIME_WIDTH-1:0]  elapsed_ff, elapsed_in;

   logic [TIME_WIDTH-1:0]  elapsed_sat;
   logic [TIME_WIDTH-1:0]  wait_dur;
   logic                   wait_done;
   logic [COUNT_WIDTH-1:0] left_dec;
   logic                   req_win;

   assign elapsed_sat = (elapsed_ff != '1) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign left_dec    = left_ff - 1'b1;
   assign req_win     = !active_ff || (item.priority_req > prio_ff);

   // One duration compare serves every wait phase.
   always_comb begin
      case (phase_ff)
         PH_WAIT_BEFORE: wait_dur = before_ff;
         PH_WAIT_ON:     wait_dur = on_ff;
         PH_WAIT_OFF:    wait_dur = off_ff;
         default:        wait_dur = after_ff;
      endcase
   end

   assign wait_done = (elapsed_sat >= wait_dur);

   always_comb begin
      phase_in   = phase_ff;
      active_in  = active_ff;
      led_in     = led_ff;
      prio_in    = prio_ff;
      before_in  = before_ff;
      after_in   = after_ff;
      on_in      = on_ff;
      off_in     = off_ff;
      left_in    = left_ff;
      elapsed_in = elapsed_ff;
      result.accepted = 1'b0;

      if (item.operation == lbs_pkg::OP_REQUEST) begin
         // A winning request replaces the pattern but keeps the phase.
         if (req_win) begin
            result.accepted = 1'b1;
            active_in = 1'b1;
            prio_in   = item.priority_req;
            before_in = TIME_WIDTH'(item.delay_before);
            after_in  = TIME_WIDTH'(item.delay_after);
            on_in     = TIME_WIDTH'(item.on_time);
            off_in    = TIME_WIDTH'(item.off_time);
            left_in   = COUNT_WIDTH'(item.cycles);
         end
      end else begin
         elapsed_in = elapsed_sat;
         unique case (phase_ff)
            PH_IDLE: begin
               if (active_ff) begin
                  led_in     = 1'b0;
                  elapsed_in = '0;
                  phase_in   = PH_WAIT_BEFORE;
               end
            end
            PH_WAIT_BEFORE: begin
               if (wait_done) phase_in = PH_SWITCH_ON;
            end
            PH_SWITCH_ON: begin
               led_in     = 1'b1;
               elapsed_in = '0;
               phase_in   = PH_WAIT_ON;
            end
            PH_WAIT_ON: begin
               if (wait_done) phase_in = PH_SWITCH_OFF;
            end
            PH_SWITCH_OFF: begin
               led_in     = 1'b0;
               elapsed_in = '0;
               phase_in   = PH_WAIT_OFF;
            end
            PH_WAIT_OFF: begin
               // The count wraps, so a count of zero runs the full range.
               if (wait_done) begin
                  left_in = left_dec;
                  if (left_dec != '0) begin
                     phase_in = PH_SWITCH_ON;
                  end else begin
                     elapsed_in = '0;
                     phase_in   = PH_WAIT_AFTER;
                  end
               end
            end
            PH_WAIT_AFTER: begin
               if (wait_done) begin
                  active_in = 1'b0;
                  phase_in  = PH_IDLE;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      result.led_on   = led_in;
      result.busy_res = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         active_ff  <= 1'b0;
         led_ff     <= 1'b0;
         prio_ff    <= '0;
         before_ff  <= '0;
         after_ff   <= '0;
         on_ff      <= '0;
         off_ff     <= '0;
         left_ff    <= '0;
         elapsed_ff <= '0;
      end else if (item_take) begin
         phase_ff   <= phase_in;
         active_ff  <= active_in;
         led_ff     <= led_in;
         prio_ff    <= prio_in;
         before_ff  <= before_in;
         after_ff   <= after_in;
         on_ff      <= on_in;
         off_ff     <= off_in;
         left_ff    <= left_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

// ===== rtl/lbs_rsp_reg.sv =====
// Result register of the LED blink sequencer; holds a result until it is
// taken, and the input side waits meanwhile. Depends on lbs_pkg for the result type.
module lbs_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  lbs_pkg::rsp_type load_data,
   output logic             load_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lbs_pkg::rsp_type rsp
);

   logic             valid_ff, valid_in;
   lbs_pkg::rsp_type data_ff;

   // A new result may enter in the same cycle the held one leaves.
   assign load_ready = !valid_ff || rsp_ready;
   assign valid_in   = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

// ===== rtl/led_blink_sequencer_top.sv =====
// Channel  | Ports                        | Moves
// ---------+------------------------------+-------------------------------
// input    | req_valid, req_ready, req    | one tick or one blink request
// result   | rsp_valid, rsp_ready, rsp    | LED level, busy, accepted flag
//
// An item can be accepted every cycle unless req_ready is low, and its
// result appears in the result register on the next cycle.
// The sequencer state updates on the same edge that accepts the item.
// Reset is synchronous and returns the sequencer to idle with the LED off.
// req_ready drops only while a result is held and rsp_ready is low.
// Depends on lbs_pkg, lbs_core and lbs_rsp_reg.
module led_blink_sequencer_top #(
   parameter int TIME_WIDTH  = lbs_pkg::TimeWidthDefault,
   parameter int COUNT_WIDTH = lbs_pkg::CountWidthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lbs_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lbs_pkg::rsp_type rsp
);

   logic             item_take;
   lbs_pkg::rsp_type core_result;

   assign item_take = req_valid && req_ready;

   lbs_core #(
      .TIME_WIDTH  (TIME_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .item_take (item_take),
      .item      (req),
      .result    (core_result)
   );

   lbs_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (item_take),
      .load_data  (core_result),
      .load_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result register not empty after reset");

   a_tick_not_accepted: assert property (@(posedge clock) disable iff (reset)
      (item_take && req.operation == lbs_pkg::OP_TICK) |=>
         (rsp_valid && !rsp.accepted))
      else $error("tick item reported as accepted");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.accepted) |-> rsp.busy_res)
      else $error("accepted request without busy");

   a_lit_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.led_on) |-> rsp.busy_res)
      else $error("LED lit while no pattern is active");

endmodule
